[rtl/core/swm_pkg.sv]
// Shared types and constants for the sliding window minimizer.
// Holds the control/status register map, field widths and the scan control struct.
// No dependencies.
package swm_pkg;

   localparam int SYMBOL_W = 8;
   localparam int OFFSET_W = 32;
   localparam int KMER_W   = 64;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;
   localparam int KLEN_W      = 4;
   localparam int WKMERS_W    = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_KMER_LEN     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_KMERS = 2'd1;

   localparam logic [KLEN_W-1:0]   KMER_LEN_RESET     = 4'd1;
   localparam logic [WKMERS_W-1:0] WINDOW_KMERS_RESET = 8'd100;

   // Control from the sequencer to the shared compare unit.
   typedef struct packed {
      logic start;   // forget the running minimum
      logic valid;   // a window entry is on the read data bus
   } scan_ctl_type;

endpackage

[rtl/core/swm_if.sv]
// Valid/ready channel interfaces for symbol beats in and minimizer beats out.
// Depends on swm_pkg for the field widths.
interface swm_req_if;
   logic                         valid;
   logic                         ready;
   logic [swm_pkg::SYMBOL_W-1:0] symbol;
   logic                         first;

   modport source (output valid, output symbol, output first, input ready);
   modport sink   (input valid, input symbol, input first, output ready);
endinterface

interface swm_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [swm_pkg::OFFSET_W-1:0] offset;
   logic [swm_pkg::KMER_W-1:0]   kmer;

   modport source (output valid, output offset, output kmer, input ready);
   modport sink   (input valid, input offset, input kmer, output ready);
endinterface

[rtl/core/sliding_window_minimizer_top.sv]
// Top level of the sliding window minimizer: sequencer, registers and result stage.
// Depends on swm_pkg, swm_if, swm_window_mem and swm_min_unit.
//
// Usage: symbols arrive one byte per beat on req_chan with a first flag that
// starts a new sequence. Once kmer_len symbols are seen, each beat forms a
// k-mer (packed big-endian) that is pushed into a ring of window entries.
// When the window holds window_kmers entries, the block scans the ring with
// one shared comparator and presents the smallest k-mer (oldest on ties) and
// its start offset on rsp_chan, unless that offset was the last one sent.
// Flow: a beat that yields no k-mer passes through the push state only, and one
// that leaves the window short of full also passes through setup. With a full
// window the beat goes on through the scan and the emit state, and its result
// turns valid at the edge where req_chan.ready rises again.
// The scan reads one ring entry per cycle through the memory's single read
// port. req_chan.ready is high only while the sequencer is idle.
// The result sits in an output register, so a new symbol is taken while the
// previous result waits; if the receiver still stalls when the next result is
// ready, the sequencer holds that result until the register frees up.
// Reset is synchronous and active high; it restores kmer_len to 1 and
// window_kmers to 100 and clears all sequence state. csr writes are taken
// whenever csr_write_en is high and must happen while the block is idle.
module sliding_window_minimizer_top #(
   parameter int MAX_KMER_LEN     = 8,
   parameter int MAX_WINDOW_KMERS = 128,
   parameter int OFFSET_BITS      = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   swm_req_if.sink                         req_chan,
   swm_rsp_if.source                       rsp_chan,
   input  logic                            csr_write_en,
   input  logic [swm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [swm_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int KW     = 8 * MAX_KMER_LEN;
   localparam int ADDR_W = $clog2(MAX_WINDOW_KMERS);
   localparam int FILL_W = $clog2(MAX_WINDOW_KMERS + 1);
   localparam int SUM_W  = ADDR_W + 1;
   localparam int ENT_W  = KW + OFFSET_BITS;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_PUSH  = 5'b00010,
      ST_SETUP = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   logic [swm_pkg::KLEN_W-1:0]    kmer_len_ff;
   logic [swm_pkg::WKMERS_W-1:0]  window_kmers_ff;
   logic [KW-1:0]                 shift_ff, shift_in;
   logic [OFFSET_BITS-1:0]        count_ff, count_in;
   logic [ADDR_W-1:0]             head_ff, head_in;
   logic [FILL_W-1:0]             fill_ff, fill_in;
   logic [OFFSET_BITS-1:0]        last_off_ff, last_off_in;
   logic                          last_valid_ff, last_valid_in;
   logic [ADDR_W-1:0]             rd_addr_ff, rd_addr_in;
   logic [FILL_W-1:0]             rd_cnt_ff, rd_cnt_in;
   logic                          rd_vld_ff, rd_vld_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [swm_pkg::OFFSET_W-1:0]  rsp_offset_ff, rsp_offset_in;
   logic [swm_pkg::KMER_W-1:0]    rsp_kmer_ff, rsp_kmer_in;

   logic [swm_pkg::KLEN_W-1:0]    eff_k;
   logic [FILL_W-1:0]             eff_w;
   logic                          req_take;
   logic [KW-1:0]                 kmask;
   logic [FILL_W:0]               fill_inc;
   logic [SUM_W-1:0]              oldest_sum;
   logic [ADDR_W-1:0]             oldest;
   logic                          issue;
   logic                          dup;
   logic                          slot_free;
   logic                          load_rsp;

   logic                          mem_we;
   logic [ENT_W-1:0]              mem_wdata;
   logic [ENT_W-1:0]              mem_rdata;
   swm_pkg::scan_ctl_type         scan_ctl;
   logic [KW-1:0]                 best_kmer;
   logic [OFFSET_BITS-1:0]        best_off;

   // Register settings, with out-of-range values folded into the legal range.
   assign eff_k = (kmer_len_ff == '0) ? swm_pkg::KLEN_W'(1) :
                  (32'(kmer_len_ff) > MAX_KMER_LEN) ? swm_pkg::KLEN_W'(MAX_KMER_LEN) :
                  kmer_len_ff;
   assign eff_w = (window_kmers_ff == '0) ? FILL_W'(1) :
                  (32'(window_kmers_ff) > MAX_WINDOW_KMERS) ? FILL_W'(MAX_WINDOW_KMERS) :
                  FILL_W'(window_kmers_ff);

   always_comb begin
      for (int b = 0; b < MAX_KMER_LEN; b++) begin
         kmask[8*b +: 8] = {8{(b < 32'(eff_k))}};
      end
   end

   assign req_take  = req_chan.valid && (state_ff == ST_IDLE);
   assign fill_inc  = {1'b0, fill_ff} + 1'b1;
   // Oldest ring slot: head minus fill, modulo the ring depth.
   assign oldest_sum = {1'b0, head_ff} + SUM_W'(MAX_WINDOW_KMERS) - SUM_W'(fill_ff);
   assign oldest     = (oldest_sum >= SUM_W'(MAX_WINDOW_KMERS)) ?
                       ADDR_W'(oldest_sum - SUM_W'(MAX_WINDOW_KMERS)) :
                       ADDR_W'(oldest_sum);
   assign issue     = (state_ff == ST_SCAN) && (rd_cnt_ff != fill_ff);
   assign dup       = last_valid_ff && (last_off_ff == best_off);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign load_rsp  = (state_ff == ST_EMIT) && !dup && slot_free;

   assign mem_we    = (state_ff == ST_PUSH) && (count_ff >= OFFSET_BITS'(eff_k));
   assign mem_wdata = {shift_ff & kmask, count_ff - OFFSET_BITS'(eff_k)};

   assign scan_ctl.start = (state_ff == ST_SETUP);
   assign scan_ctl.valid = rd_vld_ff;

   always_comb begin
      state_in      = state_ff;
      shift_in      = shift_ff;
      count_in      = count_ff;
      head_in       = head_ff;
      fill_in       = fill_ff;
      last_off_in   = last_off_ff;
      last_valid_in = last_valid_ff;
      rd_addr_in    = rd_addr_ff;
      rd_cnt_in     = rd_cnt_ff;
      rd_vld_in     = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_offset_in = rsp_offset_ff;
      rsp_kmer_in   = rsp_kmer_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_chan.first) begin
                  shift_in      = KW'(req_chan.symbol);
                  count_in      = OFFSET_BITS'(1);
                  head_in       = '0;
                  fill_in       = '0;
                  last_off_in   = '0;
                  last_valid_in = 1'b0;
               end else begin
                  shift_in = (shift_ff << 8) | KW'(req_chan.symbol);
                  if (count_ff != '1) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               state_in = ST_PUSH;
            end
         end
         ST_PUSH: begin
            if (mem_we) begin
               head_in  = (head_ff == ADDR_W'(MAX_WINDOW_KMERS - 1)) ? '0 : head_ff + 1'b1;
               fill_in  = (fill_inc > {1'b0, eff_w}) ? eff_w : FILL_W'(fill_inc);
               state_in = ST_SETUP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SETUP: begin
            if (fill_ff < eff_w) begin
               state_in = ST_IDLE;
            end else begin
               rd_addr_in = oldest;
               rd_cnt_in  = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               rd_vld_in  = 1'b1;
               rd_cnt_in  = rd_cnt_ff + 1'b1;
               rd_addr_in = (rd_addr_ff == ADDR_W'(MAX_WINDOW_KMERS - 1)) ? '0 :
                            rd_addr_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (dup) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_offset_in = swm_pkg::OFFSET_W'(best_off);
               rsp_kmer_in   = swm_pkg::KMER_W'(best_kmer);
               last_off_in   = best_off;
               last_valid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         kmer_len_ff     <= swm_pkg::KMER_LEN_RESET;
         window_kmers_ff <= swm_pkg::WINDOW_KMERS_RESET;
         shift_ff        <= '0;
         count_ff        <= '0;
         head_ff         <= '0;
         fill_ff         <= '0;
         last_off_ff     <= '0;
         last_valid_ff   <= 1'b0;
         rd_addr_ff      <= '0;
         rd_cnt_ff       <= '0;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         shift_ff      <= shift_in;
         count_ff      <= count_in;
         head_ff       <= head_in;
         fill_ff       <= fill_in;
         last_off_ff   <= last_off_in;
         last_valid_ff <= last_valid_in;
         rd_addr_ff    <= rd_addr_in;
         rd_cnt_ff     <= rd_cnt_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               swm_pkg::CSR_KMER_LEN: begin
                  kmer_len_ff <= csr_wdata[swm_pkg::KLEN_W-1:0];
               end
               swm_pkg::CSR_WINDOW_KMERS: begin
                  window_kmers_ff <= csr_wdata[swm_pkg::WKMERS_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      rsp_offset_ff <= rsp_offset_in;
      rsp_kmer_ff   <= rsp_kmer_in;
   end

   swm_window_mem #(
      .DEPTH  (MAX_WINDOW_KMERS),
      .DATA_W (ENT_W),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (head_ff),
      .wr_data (mem_wdata),
      .rd_en   (issue),
      .rd_addr (rd_addr_ff),
      .rd_data (mem_rdata)
   );

   swm_min_unit #(
      .KW (KW),
      .OW (OFFSET_BITS)
   ) u_min (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .kmer_in     (mem_rdata[ENT_W-1:OFFSET_BITS]),
      .offset_in   (mem_rdata[OFFSET_BITS-1:0]),
      .best_kmer   (best_kmer),
      .best_offset (best_off)
   );

   assign req_chan.ready  = (state_ff == ST_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.offset = rsp_offset_ff;
   assign rsp_chan.kmer   = rsp_kmer_ff;

`ifndef NO_ASSERTIONS
   // Read data only ever returns while the scan is still running.
   a_read_in_scan: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN))
      else $error("window read returned outside the scan");

   // The ring never holds more entries than it has slots.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MAX_WINDOW_KMERS)
      else $error("window fill exceeds ring depth");

   // The scan never reads more entries than the window holds.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (rd_cnt_ff <= fill_ff))
      else $error("scan ran past the window fill");

   // A loaded result shows up next cycle and is recorded as the last offset.
   a_emit_load: assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> (rsp_valid_ff && last_valid_ff &&
                    (last_off_ff == $past(best_off))))
      else $error("result load did not update output and last offset");
`endif

endmodule

[rtl/core/swm_window_mem.sv]
// Ring buffer storage for window entries: one write port, one registered read port.
// No package dependencies.
module swm_window_mem #(
   parameter int DEPTH  = 128,
   parameter int DATA_W = 96,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/swm_min_unit.sv]
// Shared compare unit that keeps the running minimum k-mer and its offset.
// Depends on swm_pkg for scan_ctl_type.
module swm_min_unit #(
   parameter int KW = 64,
   parameter int OW = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  swm_pkg::scan_ctl_type ctl,
   input  logic [KW-1:0]         kmer_in,
   input  logic [OW-1:0]         offset_in,
   output logic [KW-1:0]         best_kmer,
   output logic [OW-1:0]         best_offset
);

   logic          empty_ff, empty_in;
   logic [KW-1:0] best_kmer_ff, best_kmer_in;
   logic [OW-1:0] best_off_ff, best_off_in;
   logic          take;

   // Strictly smaller wins, so the oldest entry stays on ties.
   assign take = ctl.valid && (empty_ff || (kmer_in < best_kmer_ff));

   always_comb begin
      empty_in     = empty_ff;
      best_kmer_in = best_kmer_ff;
      best_off_in  = best_off_ff;
      if (ctl.start) begin
         empty_in = 1'b1;
      end else if (ctl.valid) begin
         empty_in = 1'b0;
      end
      if (take) begin
         best_kmer_in = kmer_in;
         best_off_in  = offset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         empty_ff <= 1'b1;
      end else begin
         empty_ff <= empty_in;
      end
      best_kmer_ff <= best_kmer_in;
      best_off_ff  <= best_off_in;
   end

   assign best_kmer   = best_kmer_ff;
   assign best_offset = best_off_ff;

endmodule

[test/swm_minimizer_checker.sv]
`timescale 1ns / 100ps
// Checker for the sliding window minimizer: watches the symbol, minimizer and register ports.
// It predicts each minimizer beat and compares the beats that the block sends.
// Depends on swm_pkg and swm_if.
module swm_minimizer_checker (
   input  logic                            clock,
   input  logic                            reset,
   swm_req_if                              req_mon,
   swm_rsp_if                              rsp_mon,
   input  logic                            csr_write_en,
   input  logic [swm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [swm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                              error_count,
   output int                              outstanding
);

   localparam int KMER_MAX_SYMS = 8;
   localparam int RING_DEPTH    = 128;
   localparam int REPORT_LIMIT  = 10;
   localparam int BEAT_W        = swm_pkg::OFFSET_W + swm_pkg::KMER_W;

   typedef struct packed {
      logic [swm_pkg::OFFSET_W-1:0] offset;
      logic [swm_pkg::KMER_W-1:0]   kmer;
   } minimizer_beat_type;

   logic [swm_pkg::KLEN_W-1:0]   kmer_len_q;
   logic [swm_pkg::WKMERS_W-1:0] window_kmers_q;

   logic [swm_pkg::KMER_W-1:0]   recent_syms;
   logic [swm_pkg::OFFSET_W-1:0] seq_pos;
   logic [swm_pkg::KMER_W-1:0]   ring_kmer [RING_DEPTH];
   logic [swm_pkg::OFFSET_W-1:0] ring_pos  [RING_DEPTH];
   logic [6:0]                   ring_head;
   int                           ring_count;
   logic [swm_pkg::OFFSET_W-1:0] last_sent_pos;
   logic                         last_sent_ok;

   minimizer_beat_type pending_minimizers[$];

   function automatic void note_failure(input string what, input logic [BEAT_W-1:0] want,
                                        input logic [BEAT_W-1:0] got);
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
         $display("%0t: minimizer %s mismatch, expected %h, got %h", $realtime, what, want, got);
      end
   endfunction

   function automatic void clear_sequence();
      recent_syms   = '0;
      seq_pos       = '0;
      ring_head     = '0;
      ring_count    = 0;
      last_sent_pos = '0;
      last_sent_ok  = 1'b0;
   endfunction

   // Pushes one symbol into the running sequence and queues the minimizer it yields, if any.
   task automatic advance_window(input logic [swm_pkg::SYMBOL_W-1:0] sym, input logic first_flag);
      int                         klen;
      int                         wlen;
      logic [swm_pkg::KMER_W-1:0] kval;
      logic [6:0]                 oldest;
      logic [6:0]                 idx;
      minimizer_beat_type         best;

      klen = (kmer_len_q == 0) ? 1 :
             (int'(kmer_len_q) > KMER_MAX_SYMS) ? KMER_MAX_SYMS : int'(kmer_len_q);
      wlen = (window_kmers_q == 0) ? 1 :
             (int'(window_kmers_q) > RING_DEPTH) ? RING_DEPTH : int'(window_kmers_q);
      if (first_flag) clear_sequence();

      recent_syms = {recent_syms[swm_pkg::KMER_W-swm_pkg::SYMBOL_W-1:0], sym};
      if (seq_pos != '1) seq_pos++;
      if (seq_pos < swm_pkg::OFFSET_W'(klen)) return;

      kval = recent_syms & ({swm_pkg::KMER_W{1'b1}} >> (swm_pkg::KMER_W - 8 * klen));
      ring_kmer[ring_head] = kval;
      ring_pos[ring_head]  = seq_pos - swm_pkg::OFFSET_W'(klen);
      ring_head++;
      ring_count = (ring_count + 1 > wlen) ? wlen : ring_count + 1;
      if (ring_count < wlen) return;

      // Scan from the oldest entry; a strict compare keeps the oldest one on ties.
      oldest      = ring_head - 7'(ring_count);
      best.kmer   = ring_kmer[oldest];
      best.offset = ring_pos[oldest];
      for (int i = 1; i < ring_count; i++) begin
         idx = oldest + 7'(i);
         if (ring_kmer[idx] < best.kmer) begin
            best.kmer   = ring_kmer[idx];
            best.offset = ring_pos[idx];
         end
      end

      if (last_sent_ok && last_sent_pos == best.offset) return;
      last_sent_pos = best.offset;
      last_sent_ok  = 1'b1;
      pending_minimizers = {pending_minimizers, best};
   endtask

   initial error_count = 0;

   always @(posedge clock) begin
      minimizer_beat_type want;
      if (reset) begin
         kmer_len_q     = swm_pkg::KMER_LEN_RESET;
         window_kmers_q = swm_pkg::WINDOW_KMERS_RESET;
         clear_sequence();
         pending_minimizers.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               swm_pkg::CSR_KMER_LEN:     kmer_len_q = csr_wdata[swm_pkg::KLEN_W-1:0];
               swm_pkg::CSR_WINDOW_KMERS: window_kmers_q = csr_wdata[swm_pkg::WKMERS_W-1:0];
               default: ;
            endcase
         end
         // The result side is checked first, so a beat can never match an expectation
         // that is only queued at this same edge.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_minimizers.size() == 0) begin
               note_failure("beat without prediction", '0, {rsp_mon.offset, rsp_mon.kmer});
            end else begin
               want = pending_minimizers.pop_front();
               if (want.offset !== rsp_mon.offset) note_failure("offset",
                                                                BEAT_W'(want.offset),
                                                                BEAT_W'(rsp_mon.offset));
               if (want.kmer !== rsp_mon.kmer) note_failure("kmer", BEAT_W'(want.kmer),
                                                            BEAT_W'(rsp_mon.kmer));
            end
         end
         if (req_mon.valid && req_mon.ready) advance_window(req_mon.symbol, req_mon.first);
      end
      outstanding <= pending_minimizers.size();
   end

endmodule

[test/sliding_window_minimizer_top_tb.sv]
`timescale 1ns / 100ps
// Top of the sliding window minimizer testbench: clock, reset, symbol stimulus and verdict.
// Depends on swm_pkg, swm_if, sliding_window_minimizer_top and swm_minimizer_checker.
module sliding_window_minimizer_top_tb;

   // Index values that map to no register; writes to them must change nothing.
   localparam logic [swm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [swm_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int RANDOM_SYMBOLS = 1600;
   // Long enough to cover a full window scan still in flight for a symbol
   // that yields no minimizer.
   localparam int QUIET_CYCLES   = 150;
   localparam int HOLD_CYCLES    = 400;

   // Alphabets for random sequences; the narrow ones make equal k-mers, and so ties, common.
   typedef enum int {ALPHA_BYTES, ALPHA_BASES, ALPHA_EXTREMES, ALPHA_BITS} alphabet_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_write_en;
   logic [swm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [swm_pkg::CSR_DATA_W-1:0]  csr_wdata;
   int                              error_count;
   int                              outstanding;

   // Idling controls. The sender's rate is only used by the stimulus process; the
   // receiver's rate and the hold-off request are read by the receiver process.
   int src_idle_pct;
   int sink_stall_pct;
   int hold_req_seq;
   int hold_seen;
   int hold_left;

   // Effective register values, used to size the random sequences.
   int klen_eff;
   int window_eff;

   swm_req_if req_chan ();
   swm_rsp_if rsp_chan ();

   sliding_window_minimizer_top uut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   swm_minimizer_checker minimizer_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .error_count  (error_count),
      .outstanding  (outstanding)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver. A hold-off request closes ready for a long stretch, counted here, so the
   // result register and the sequencer fill up and the block stops taking symbols.
   // Otherwise ready drops at random at the phase's stall rate.
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (hold_req_seq != hold_seen) begin
         rsp_chan.ready <= 1'b0;
         hold_seen      <= hold_req_seq;
         hold_left      <= HOLD_CYCLES;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
   end

   // Writes one register. The enable drops again before the task returns, so back to back
   // calls never assign the enable twice in one time step.
   task automatic write_reg(input logic [swm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [swm_pkg::CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // Sets both registers. The upper bits of the k-mer length beat are random since the
   // block must ignore them; now and then a write to an unmapped index is thrown in.
   task automatic configure(input logic [swm_pkg::KLEN_W-1:0] klen,
                            input logic [swm_pkg::WKMERS_W-1:0] wkmers);
      write_reg(swm_pkg::CSR_KMER_LEN, {4'($urandom_range(15)), klen});
      write_reg(swm_pkg::CSR_WINDOW_KMERS, wkmers);
      if ($urandom_range(3) == 0) begin
         write_reg($urandom_range(1) ? CSR_SPARE_A : CSR_SPARE_B, 8'($urandom_range(255)));
      end
      klen_eff   = (klen == 0) ? 1 : (klen > 8) ? 8 : int'(klen);
      window_eff = (wkmers == 0) ? 1 : (wkmers > 128) ? 128 : int'(wkmers);
   endtask

   // Offers one symbol beat and returns at the edge where it is taken. Valid stays high
   // after the beat, so a following beat without a gap does not touch it twice.
   task automatic send_symbol(input logic [swm_pkg::SYMBOL_W-1:0] sym, input logic first_flag);
      if ($urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < src_idle_pct);
      end
      req_chan.valid  <= 1'b1;
      req_chan.symbol <= sym;
      req_chan.first  <= first_flag;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Stops sending, waits for every predicted minimizer, then lets a scan in flight end.
   task automatic wait_for_quiet();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   function automatic logic [swm_pkg::SYMBOL_W-1:0] pick_symbol(input alphabet_type alpha);
      case (alpha)
         ALPHA_BASES: begin
            case ($urandom_range(3))
               0: return "A";
               1: return "C";
               2: return "G";
               default: return "T";
            endcase
         end
         ALPHA_EXTREMES: return $urandom_range(1) ? 8'hFF : 8'h00;
         ALPHA_BITS:     return 8'($urandom_range(1));
         default:        return 8'($urandom_range(255));
      endcase
   endfunction

   // Raw k-mer length, with the out-of-range values that clamp to 1 and to 8 kept frequent.
   function automatic logic [swm_pkg::KLEN_W-1:0] pick_klen();
      if ($urandom_range(99) < 30) begin
         case ($urandom_range(3))
            0: return 4'd0;
            1: return 4'd1;
            2: return 4'd8;
            default: return 4'd15;
         endcase
      end
      return 4'($urandom_range(15));
   endfunction

   // Mostly small windows, since every symbol costs a scan of the whole window.
   function automatic logic [swm_pkg::WKMERS_W-1:0] pick_window();
      int r;
      r = $urandom_range(99);
      if (r < 8) return 8'd0;
      if (r < 25) return 8'($urandom_range(9, 40));
      return 8'($urandom_range(1, 8));
   endfunction

   initial begin
      int           symbols_sent;
      int           phase_no;
      int           phase_len;
      int           seq_left;
      logic         first_flag;
      alphabet_type alpha;

      reset          = 1'b1;
      csr_write_en   = 1'b0;
      csr_index      = '0;
      csr_wdata      = '0;
      req_chan.valid = 1'b0;
      req_chan.symbol = '0;
      req_chan.first = 1'b0;
      rsp_chan.ready = 1'b0;
      src_idle_pct   = 0;
      sink_stall_pct = 0;
      hold_req_seq   = 0;
      hold_seen      = 0;
      hold_left      = 0;
      symbols_sent   = 0;
      seq_left       = 0;
      first_flag     = 1'b0;
      alpha          = ALPHA_BYTES;

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A sequence that starts with byte extremes and runs of zero k-mers,
      // so the window holds ties and the repeated-offset suppression comes into play.
      configure(4'd3, 8'd2);
      write_reg(CSR_SPARE_A, 8'hFF);
      write_reg(CSR_SPARE_B, 8'h00);
      send_symbol(8'hFF, 1'b1);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h00, 1'b0);
      send_symbol(8'h80, 1'b0);
      send_symbol(8'h7F, 1'b0);

      // The window shrinks in the middle of the sequence.
      wait_for_quiet();
      configure(4'd3, 8'd2 - 8'd1);
      send_symbol(8'h01, 1'b0);
      send_symbol(8'hFE, 1'b0);

      // Zero in both registers acts as one.
      wait_for_quiet();
      configure(4'd0, 8'd0);
      send_symbol(8'h55, 1'b0);
      send_symbol(8'hAA, 1'b0);

      // An oversized k-mer length acts as eight, and the window grows by one per k-mer,
      // while the stored short k-mers keep their values.
      wait_for_quiet();
      configure(4'd15, 8'd3);
      send_symbol(8'h12, 1'b0);
      send_symbol(8'h34, 1'b0);
      send_symbol(8'h56, 1'b0);
      send_symbol(8'h78, 1'b0);

      // A new sequence shorter than one k-mer yields nothing.
      wait_for_quiet();
      configure(4'd8, 8'd3);
      send_symbol(8'h00, 1'b1);
      send_symbol(8'hFF, 1'b0);
      send_symbol(8'h00, 1'b0);

      // Random part in phases. Each phase starts from an idle block, sets the registers and
      // its idling pattern, then sends sequences that mostly run past the window fill, with
      // some broken ones no longer than one k-mer. A phase may continue the open sequence, so
      // register changes also land in the middle of sequences.
      for (phase_no = 0; symbols_sent < RANDOM_SYMBOLS; phase_no++) begin
         wait_for_quiet();
         case (phase_no % 4)
            0: begin
               src_idle_pct   = 0;
               sink_stall_pct <= 0;
            end
            1: begin
               src_idle_pct   = 81;
               sink_stall_pct <= 0;
            end
            2: begin
               src_idle_pct   = 0;
               sink_stall_pct <= 81;
            end
            default: begin
               src_idle_pct   = 12;
               sink_stall_pct <= 12;
            end
         endcase

         if (phase_no == 1) configure(4'd1, 8'd1);
         else if (phase_no == 2) configure(pick_klen(), 8'd128);
         else if (phase_no == 5) configure(pick_klen(), 8'd255);
         else configure(pick_klen(), pick_window());

         phase_len = (window_eff >= 100) ? 300 : $urandom_range(30, 90);
         if (phase_no == 1) begin
            // Every k-mer is a minimizer here, so a long receiver hold-off backs the block
            // up while the sender keeps offering beats.
            phase_len    = 60;
            hold_req_seq <= hold_req_seq + 1;
         end
         if ($urandom_range(9) < 7) seq_left = 0;

         repeat (phase_len) begin
            if (seq_left == 0) begin
               if ($urandom_range(99) < 15) begin
                  seq_left = $urandom_range(1, klen_eff);
               end else begin
                  seq_left = $urandom_range(klen_eff + window_eff - 1,
                                            klen_eff + 3 * window_eff + 8);
               end
               alpha      = alphabet_type'($urandom_range(3));
               first_flag = 1'b1;
            end
            send_symbol(pick_symbol(alpha), first_flag);
            first_flag = 1'b0;
            seq_left--;
            symbols_sent++;
         end
      end

      wait_for_quiet();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog, several times the slowest correct run with full windows and stalls.
   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
